// ===== src/csu_pkg.sv =====
`default_nettype none
package csu_pkg;

  typedef struct packed {
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [15:0] similarity;
    logic               zero_norm;
    logic               too_long;
  } result_t;

  // one finished vector waiting for the multiply, root and divide
  typedef struct packed {
    logic signed [42:0] dot;
    logic [41:0]        norm_a;
    logic [41:0]        norm_b;
    logic               zero_norm;
    logic               too_long;
  } job_t;

  localparam logic signed [43:0] DOT_MAX = 44'sd4398046511103;
  localparam logic signed [43:0] DOT_MIN = -44'sd4398046511104;
  localparam logic [42:0]        NORM_MAX = 43'd4398046511103;

endpackage
`default_nettype wire

// ===== src/csu_front.sv =====
`default_nettype none
module csu_front
  import csu_pkg::*;
#(
  parameter int MAX_LEN = 2048
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t item,
  input  wire logic  accept,
  output job_t       job,
  output logic       job_push
);

  localparam int CW = $clog2(MAX_LEN + 2);
  localparam logic [CW-1:0] LIMIT = CW'(MAX_LEN);

  logic signed [42:0] dot_acc;
  logic [41:0]        norm_a_acc;
  logic [41:0]        norm_b_acc;
  logic [CW-1:0]      elem_count;

  logic signed [31:0] p_ab, p_aa, p_bb;
  logic signed [43:0] dot_sum;
  logic [42:0]        na_sum, nb_sum;
  logic signed [42:0] dot_next;
  logic [41:0]        na_next, nb_next;
  logic [CW-1:0]      count_next;

  always_comb begin
    p_ab = item.elem_a * item.elem_b;
    p_aa = item.elem_a * item.elem_a;
    p_bb = item.elem_b * item.elem_b;
    dot_sum = 44'(dot_acc) + 44'(p_ab);
    na_sum = 43'(norm_a_acc) + 43'(unsigned'(p_aa));
    nb_sum = 43'(norm_b_acc) + 43'(unsigned'(p_bb));
    if (dot_sum > DOT_MAX) dot_next = DOT_MAX[42:0];
    else if (dot_sum < DOT_MIN) dot_next = DOT_MIN[42:0];
    else dot_next = dot_sum[42:0];
    na_next = (na_sum > NORM_MAX) ? NORM_MAX[41:0] : na_sum[41:0];
    nb_next = (nb_sum > NORM_MAX) ? NORM_MAX[41:0] : nb_sum[41:0];
    count_next = (elem_count <= LIMIT) ? elem_count + 1'b1 : elem_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc <= '0;
      norm_a_acc <= '0;
      norm_b_acc <= '0;
      elem_count <= '0;
      job_push <= 1'b0;
    end else begin
      job_push <= accept && item.last;
      if (accept) begin
        if (item.last) begin
          dot_acc <= '0;
          norm_a_acc <= '0;
          norm_b_acc <= '0;
          elem_count <= '0;
        end else begin
          dot_acc <= dot_next;
          norm_a_acc <= na_next;
          norm_b_acc <= nb_next;
          elem_count <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.last) begin
      job.dot <= dot_next;
      job.norm_a <= na_next;
      job.norm_b <= nb_next;
      job.zero_norm <= (na_next == '0) || (nb_next == '0);
      job.too_long <= count_next > LIMIT;
    end
  end

endmodule
`default_nettype wire

// ===== src/csu_fifo.sv =====
`default_nettype none
module csu_fifo
  import csu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t wr_data,
  input  wire logic wr,
  output logic      full,
  output job_t      rd_data,
  output logic      valid,
  input  wire logic rd
);

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign valid = count != 2'd0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule
`default_nettype wire

// ===== src/csu_back.sv =====
`default_nettype none
module csu_back
  import csu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t job,
  input  wire logic job_valid,
  output logic      job_pop,
  output result_t   result,
  output logic      result_valid,
  input  wire logic pop
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam int SQRT_STEPS = 42;
  localparam int DIV_STEPS = 58;

  logic [2:0]  state;
  logic [5:0]  cnt;
  logic [41:0] na, nb;
  logic        neg, zn, tl;
  logic [41:0] pp;
  logic [1:0]  pp_idx;
  logic [83:0] prod;
  logic [43:0] rem;
  logic [41:0] root;
  logic [57:0] dvd;
  logic [57:0] quo;
  logic [42:0] mag;
  logic signed [15:0] sim;

  logic [20:0] mul_a, mul_b;
  logic [83:0] pp_shifted;
  logic [45:0] s_rem, s_trial;
  logic [41:0] divisor;
  logic [43:0] d_rem;
  logic        out_free;

  assign out_free = !result_valid || pop;
  assign job_pop = (state == S_IDLE) && job_valid;

  always_comb begin
    mul_a = cnt[1] ? na[41:21] : na[20:0];
    mul_b = cnt[0] ? nb[41:21] : nb[20:0];
    case (pp_idx)
      2'd0:    pp_shifted = 84'(pp);
      2'd3:    pp_shifted = 84'(pp) << 42;
      default: pp_shifted = 84'(pp) << 21;
    endcase
    s_rem = {rem, prod[83:82]};
    s_trial = {2'b00, root, 2'b01};
    divisor = (root == '0) ? 42'd1 : root;
    d_rem = {rem[42:0], dvd[57]};
    if (neg) sim = (quo > 58'd32768) ? -16'sd32768 : -16'(signed'(quo[15:0]));
    else sim = (quo > 58'd32767) ? 16'sd32767 : 16'(signed'(quo[15:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      result_valid <= 1'b0;
    end else begin
      if (pop && !(state == S_OUT && out_free)) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (job_valid) state <= job.zero_norm ? S_OUT : S_MUL;
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'd4) begin
            cnt <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'(SQRT_STEPS - 1)) begin
            cnt <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'(DIV_STEPS - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        na <= job.norm_a;
        nb <= job.norm_b;
        neg <= job.dot < 0;
        mag <= (job.dot < 0) ? 43'(-job.dot) : 43'(job.dot);
        zn <= job.zero_norm;
        tl <= job.too_long;
        prod <= '0;
        rem <= '0;
        root <= '0;
        quo <= '0;
      end
      S_MUL: begin
        if (cnt != 6'd4) begin
          pp <= 42'(mul_a * mul_b);
          pp_idx <= cnt[1:0];
        end
        if (cnt != 6'd0) prod <= prod + pp_shifted;
      end
      S_SQRT: begin
        // two radicand bits per step, one root bit out
        prod <= prod << 2;
        if (s_rem >= s_trial) begin
          rem <= 44'(s_rem - s_trial);
          root <= {root[40:0], 1'b1};
        end else begin
          rem <= s_rem[43:0];
          root <= {root[40:0], 1'b0};
        end
        if (cnt == 6'(SQRT_STEPS - 1)) dvd <= {mag, 15'd0};
      end
      S_DIV: begin
        if (cnt == 6'd0) begin
          // restart remainder for the divide
          if (44'({dvd[57]}) >= 44'(divisor)) begin
            rem <= 44'({dvd[57]}) - 44'(divisor);
            quo <= 58'd1;
          end else begin
            rem <= 44'({dvd[57]});
            quo <= 58'd0;
          end
        end else if (d_rem >= 44'(divisor)) begin
          rem <= d_rem - 44'(divisor);
          quo <= {quo[56:0], 1'b1};
        end else begin
          rem <= d_rem;
          quo <= {quo[56:0], 1'b0};
        end
        dvd <= dvd << 1;
      end
      S_OUT: begin
        if (out_free) begin
          result.similarity <= zn ? 16'sd0 : sim;
          result.zero_norm <= zn;
          result.too_long <= tl;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/cosine_similarity_unit_top.sv =====
// cosine similarity of two streamed Q1.15 vectors
// input channel: drive item and push; a request is taken on a clock edge
// with push high and full low. one element pair per cycle is accepted while full stays low; the
// pair with last set closes the vector and is folded in like the others.
// result channel: while empty is low, result holds the oldest finished
// vector (similarity, zero_norm, too_long); pop high takes it.
// a closed vector is handed to a two-entry queue; a sequencer then runs
// a four-step partial-product multiply of the norms, a 42-step bit-serial
// square root and a 58-step restoring divide, and takes one vector at a
// time. short vectors are limited by this sequencer; the queue lets two
// closed vectors wait while new elements keep streaming in. zero-norm
// vectors skip the arithmetic and go straight from idle to the output stage.
// if pop is held low the finished result stays in the output register, the
// sequencer waits and full rises once the queue is full or holds a vector while another is on its way in.
// synchronous reset clears accumulators, queue and output (empty goes high).
`default_nettype none
module cosine_similarity_unit_top
  import csu_pkg::*;
#(
  parameter int MAX_LEN = 2048
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t item,
  input  wire logic  push,
  output logic       full,
  output result_t    result,
  output logic       empty,
  input  wire logic  pop
);

  job_t front_job, q_job;
  logic front_push, q_full, q_valid, q_pop, res_valid, accept;

  // a closing request waits while the queue may not take it
  assign full = q_full || (front_push && q_valid && !q_pop);
  assign accept = push && !full;
  assign empty = !res_valid;

  csu_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk(clk), .rst(rst), .item(item), .accept(accept),
    .job(front_job), .job_push(front_push)
  );

  csu_fifo u_fifo (
    .clk(clk), .rst(rst), .wr_data(front_job), .wr(front_push), .full(q_full),
    .rd_data(q_job), .valid(q_valid), .rd(q_pop)
  );

  csu_back u_back (
    .clk(clk), .rst(rst), .job(q_job), .job_valid(q_valid), .job_pop(q_pop),
    .result(result), .result_valid(res_valid), .pop(pop)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(front_push && q_full && !q_pop))
    else $error("job queue overflow");
  a_zero_sim: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.zero_norm) |-> (result.similarity == 16'sd0))
    else $error("zero norm with nonzero similarity");
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");
`endif

endmodule
`default_nettype wire
